// ----- hw/rtl/mes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mes_pkg;

   localparam int DEFAULT_TRACKS        = 16;
   localparam int DEFAULT_FIFO_DEPTH    = 32;
   localparam int DEFAULT_DELAY_DIVIDER = 1;

   localparam int DELAY_W   = 32;
   localparam int MSG_W     = 24;
   localparam int TRACK_W   = 4;
   localparam int EVENT_W   = DELAY_W + MSG_W;
   localparam int EMIT_W    = 6;
   localparam int EMIT_CAP  = 63;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int ENABLE_W  = 16;

   localparam logic CSR_TRACK_ENABLE = 1'b0;

   typedef struct packed {
      logic push;
      logic tick;
      logic init_scan;
      logic next_track;
      logic add_elapsed;
      logic load_read;
      logic set_invalid;
      logic div_start;
      logic load_write;
      logic emit_event;
      logic calc_wait;
      logic min_update;
      logic report_sleep;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic wake_ok;
      logic scan_done;
      logic track_en;
      logic cur_valid;
      logic fifo_empty;
      logic div_done;
      logic due;
   } status_type;

   function automatic logic [DELAY_W-1:0] add_sat(input logic [DELAY_W-1:0] a,
                                                  input logic [DELAY_W-1:0] b);
      logic [DELAY_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DELAY_W] ? {DELAY_W{1'b1}} : s[DELAY_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mes_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mes_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mes_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_op,
   input  wire mes_pkg::status_type sts,
   output mes_pkg::cmd_type         cmd,
   output logic                     busy
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_TRACK  = 4'd2;
   localparam logic [3:0] S_LOAD   = 4'd3;
   localparam logic [3:0] S_LWAIT  = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_TEST   = 4'd6;
   localparam logic [3:0] S_MINUPD = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   localparam logic OP_PUSH = 1'b0;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_op == OP_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.tick = 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sts.wake_ok) begin
               cmd.init_scan = 1'b1;
               state_in      = S_TRACK;
            end else begin
               cmd.report_sleep = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_TRACK: begin
            priority if (sts.scan_done) begin
               state_in = S_FINISH;
            end else if (!sts.track_en) begin
               cmd.next_track = 1'b1;
            end else begin
               cmd.add_elapsed = 1'b1;
               state_in = sts.cur_valid ? S_TEST : S_LOAD;
            end
         end
         S_LOAD: begin
            if (sts.fifo_empty) begin
               cmd.set_invalid = 1'b1;
               state_in        = S_TEST;
            end else begin
               cmd.load_read = 1'b1;
               state_in      = S_LWAIT;
            end
         end
         S_LWAIT: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.load_write = 1'b1;
               state_in       = S_TEST;
            end
         end
         S_TEST: begin
            if (sts.due) begin
               cmd.emit_event = 1'b1;
               state_in       = S_LOAD;
            end else begin
               cmd.calc_wait = 1'b1;
               state_in      = S_MINUPD;
            end
         end
         S_MINUPD: begin
            cmd.min_update = 1'b1;
            cmd.next_track = 1'b1;
            state_in       = S_TRACK;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/mes_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mes_datapath #(
   parameter int TRACKS        = mes_pkg::DEFAULT_TRACKS,
   parameter int FIFO_DEPTH    = mes_pkg::DEFAULT_FIFO_DEPTH,
   parameter int DELAY_DIVIDER = mes_pkg::DEFAULT_DELAY_DIVIDER
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mes_pkg::cmd_type              cmd,
   output mes_pkg::status_type                sts,
   input  wire logic [mes_pkg::ENABLE_W-1:0]  track_enable,
   input  wire logic [mes_pkg::TRACK_W-1:0]   req_track,
   input  wire logic [mes_pkg::DELAY_W-1:0]   req_event_delay,
   input  wire logic [mes_pkg::MSG_W-1:0]     req_event_message,
   input  wire logic [mes_pkg::DELAY_W-1:0]   req_tick_delta,
   output logic                               rsp_strobe,
   output logic                               rsp_is_event,
   output logic      [mes_pkg::TRACK_W-1:0]   rsp_track_index,
   output logic      [mes_pkg::MSG_W-1:0]     rsp_message,
   output logic      [mes_pkg::DELAY_W-1:0]   rsp_next_wait,
   output logic                               rsp_last
);

   localparam int DW     = mes_pkg::DELAY_W;
   localparam int MW     = mes_pkg::MSG_W;
   localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int TCNT_W = TIDX_W + 1;
   localparam int SLOT_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W = TIDX_W + SLOT_W;
   localparam int RAM_DEPTH = 1 << ADDR_W;
   localparam bit BYPASS = (DELAY_DIVIDER == 1);
   localparam int RECIP_L = $clog2(DELAY_DIVIDER);
   localparam logic [63:0] RECIP_FULL = (64'd1 << (DW + RECIP_L)) / 64'(DELAY_DIVIDER);
   localparam logic [DW-1:0] RECIP_LO = DW'(RECIP_FULL);
   localparam logic [DW-1:0] DIVISOR = DW'(DELAY_DIVIDER);

   localparam logic [2:0] DIV_MUL  = 3'd4;
   localparam logic [2:0] DIV_QUO  = 3'd3;
   localparam logic [2:0] DIV_BACK = 3'd2;
   localparam logic [2:0] DIV_FIX  = 3'd1;

   logic [SLOT_W-1:0] head_ff    [TRACKS];
   logic [CNT_W-1:0]  count_ff   [TRACKS];
   logic [DW-1:0]     elapsed_ff [TRACKS];
   logic [DW-1:0]     delay_ff   [TRACKS];
   logic [MW-1:0]     msg_ff     [TRACKS];
   logic [TRACKS-1:0] valid_ff;

   logic [DW-1:0]     global_ff, wake_ff, min_ff, wait_ff;
   logic [TCNT_W-1:0] t_ff;
   logic [mes_pkg::EMIT_W-1:0] emitted_ff;
   logic [DW-1:0]     div_x_ff;
   logic [DW-1:0]     div_q_ff;
   logic [MW-1:0]     div_msg_ff;
   logic [2*DW-1:0]   div_mul_ff;
   logic [2*DW-1:0]   div_back_ff;
   logic [2:0]        div_cnt_ff;

   logic [TIDX_W-1:0] ti, pi, sel;
   logic              push_ok, full;
   logic [SLOT_W-1:0] head_sel, head_inc, slot;
   logic [CNT_W-1:0]  cnt_sel;
   logic [CNT_W:0]    slot_sum;
   logic [DW-1:0]     global_in, cur_delay, cur_elapsed;
   logic [2*DW:0]     div_sum;
   logic [DW-1:0]     div_rem;
   logic [mes_pkg::EVENT_W-1:0] rdata;

   assign ti  = t_ff[TIDX_W-1:0];
   assign pi  = req_track[TIDX_W-1:0];
   assign sel = cmd.push ? pi : ti;

   assign head_sel = head_ff[sel];
   assign cnt_sel  = count_ff[sel];
   assign head_inc = (head_sel == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : head_sel + 1'b1;
   assign full     = (cnt_sel == CNT_W'(FIFO_DEPTH));
   assign slot_sum = (CNT_W + 1)'(head_sel) + (CNT_W + 1)'(cnt_sel);
   assign slot     = full ? head_sel :
                     (slot_sum >= (CNT_W + 1)'(FIFO_DEPTH)) ?
                     SLOT_W'(slot_sum - (CNT_W + 1)'(FIFO_DEPTH)) : SLOT_W'(slot_sum);
   assign push_ok  = ({1'b0, req_track} < 5'(TRACKS));

   assign global_in   = mes_pkg::add_sat(global_ff, req_tick_delta);
   assign cur_delay   = delay_ff[ti];
   assign cur_elapsed = elapsed_ff[ti];
   assign div_sum     = {1'b0, div_x_ff, {DW{1'b0}}} + {1'b0, div_mul_ff};
   assign div_rem     = div_x_ff - div_back_ff[DW-1:0];

   mes_ram #(
      .WIDTH (mes_pkg::EVENT_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.push && push_ok),
      .waddr ({pi, slot}),
      .wdata ({req_event_delay, req_event_message}),
      .raddr ({ti, head_sel}),
      .rdata (rdata)
   );

   always_comb begin
      sts.wake_ok    = (global_ff >= wake_ff);
      sts.scan_done  = (t_ff >= TCNT_W'(TRACKS));
      sts.track_en   = track_enable[ti];
      sts.cur_valid  = valid_ff[ti];
      sts.fifo_empty = (cnt_sel == '0);
      sts.div_done   = BYPASS || (div_cnt_ff == '0);
      sts.due        = valid_ff[ti] && (cur_delay < cur_elapsed) &&
                       (emitted_ff != mes_pkg::EMIT_W'(mes_pkg::EMIT_CAP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRACKS; i++) begin
            head_ff[i]    <= '0;
            count_ff[i]   <= '0;
            elapsed_ff[i] <= '0;
            delay_ff[i]   <= '0;
            msg_ff[i]     <= '0;
         end
         valid_ff   <= '0;
         global_ff  <= '0;
         wake_ff    <= '0;
         min_ff     <= '1;
         wait_ff    <= '0;
         t_ff       <= '0;
         emitted_ff <= '0;
         div_cnt_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit_event || cmd.report_sleep || cmd.finish;
         if (cmd.push && push_ok) begin
            if (full) begin
               head_ff[pi] <= head_inc;
            end else begin
               count_ff[pi] <= cnt_sel + 1'b1;
            end
         end
         if (cmd.tick) begin
            global_ff <= global_in;
         end
         if (cmd.init_scan) begin
            t_ff       <= '0;
            min_ff     <= '1;
            emitted_ff <= '0;
         end
         if (cmd.next_track) begin
            t_ff <= t_ff + 1'b1;
         end
         if (cmd.add_elapsed) begin
            elapsed_ff[ti] <= mes_pkg::add_sat(cur_elapsed, global_ff);
         end
         if (cmd.set_invalid) begin
            valid_ff[ti] <= 1'b0;
         end
         if (cmd.load_read) begin
            head_ff[ti]  <= head_inc;
            count_ff[ti] <= cnt_sel - 1'b1;
         end
         if (cmd.div_start) begin
            div_cnt_ff <= BYPASS ? 3'd0 : DIV_MUL;
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (cmd.load_write) begin
            delay_ff[ti] <= div_q_ff;
            msg_ff[ti]   <= div_msg_ff;
            valid_ff[ti] <= 1'b1;
         end
         if (cmd.emit_event) begin
            elapsed_ff[ti] <= cur_elapsed - cur_delay;
            emitted_ff     <= emitted_ff + 1'b1;
         end
         if (cmd.calc_wait) begin
            wait_ff <= (cur_delay >= cur_elapsed) ? cur_delay - cur_elapsed : '0;
         end
         if (cmd.min_update && valid_ff[ti] && (wait_ff < min_ff)) begin
            min_ff <= wait_ff;
         end
         if (cmd.finish) begin
            global_ff  <= '0;
            wake_ff    <= min_ff;
         end
      end
   end

   // reciprocal multiply by the constant divider with one correction step
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_x_ff   <= rdata[mes_pkg::EVENT_W-1:MW];
         div_q_ff   <= rdata[mes_pkg::EVENT_W-1:MW];
         div_msg_ff <= rdata[MW-1:0];
      end else begin
         if (div_cnt_ff == DIV_MUL) begin
            div_mul_ff <= (2*DW)'(div_x_ff) * (2*DW)'(RECIP_LO);
         end
         if (div_cnt_ff == DIV_QUO) begin
            div_q_ff <= DW'(div_sum >> (DW + RECIP_L));
         end
         if (div_cnt_ff == DIV_BACK) begin
            div_back_ff <= (2*DW)'(div_q_ff) * (2*DW)'(DIVISOR);
         end
         if ((div_cnt_ff == DIV_FIX) && (div_rem >= DIVISOR)) begin
            div_q_ff <= div_q_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_event) begin
         rsp_is_event    <= 1'b1;
         rsp_track_index <= mes_pkg::TRACK_W'(ti);
         rsp_message     <= msg_ff[ti];
         rsp_next_wait   <= '0;
         rsp_last        <= 1'b0;
      end else if (cmd.report_sleep || cmd.finish) begin
         rsp_is_event    <= 1'b0;
         rsp_track_index <= '0;
         rsp_message     <= '0;
         rsp_next_wait   <= cmd.finish ? min_ff : '1;
         rsp_last        <= 1'b1;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/multitrack_event_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                         transfer when
// request   start, busy, req_*            start high and busy low
// result    rsp_strobe, rsp_*             rsp_strobe high, one cycle each
// csr       psel, penable, pwrite, paddr  psel, penable, pwrite, pready high
//
// a push gives no result; busy stays low
// a tick checks wake, then skips disabled tracks; an enabled one adds elapsed time,
// loads its fifo (via the delay divider unless that is one), emits each due event
// and updates the minimum wait; a report closes it; a sleeping tick only reports
// synchronous reset clears all track state; store contents are not cleared
// results cannot be stalled; each stands on the rsp_ ports for one cycle
module multitrack_event_scheduler #(
   parameter int TRACKS        = mes_pkg::DEFAULT_TRACKS,
   parameter int FIFO_DEPTH    = mes_pkg::DEFAULT_FIFO_DEPTH,
   parameter int DELAY_DIVIDER = mes_pkg::DEFAULT_DELAY_DIVIDER
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_op,
   input  wire logic [mes_pkg::TRACK_W-1:0]     req_track,
   input  wire logic [mes_pkg::DELAY_W-1:0]     req_event_delay,
   input  wire logic [mes_pkg::MSG_W-1:0]       req_event_message,
   input  wire logic [mes_pkg::DELAY_W-1:0]     req_tick_delta,
   output logic                                 rsp_strobe,
   output logic                                 rsp_is_event,
   output logic      [mes_pkg::TRACK_W-1:0]     rsp_track_index,
   output logic      [mes_pkg::MSG_W-1:0]       rsp_message,
   output logic      [mes_pkg::DELAY_W-1:0]     rsp_next_wait,
   output logic                                 rsp_last,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [mes_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mes_pkg::CSR_W-1:0]       pwdata,
   output logic      [mes_pkg::CSR_W-1:0]       prdata,
   output logic                                 pready
);

   mes_pkg::cmd_type    cmd;
   mes_pkg::status_type sts;

   logic [mes_pkg::ENABLE_W-1:0] track_enable_ff;
   logic                         csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == mes_pkg::CSR_TRACK_ENABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         track_enable_ff <= '0;
      end else if (psel && penable && pwrite && csr_hit) begin
         track_enable_ff <= pwdata[mes_pkg::ENABLE_W-1:0];
      end
   end

   assign prdata = csr_hit ? mes_pkg::CSR_W'(track_enable_ff) : '0;

   mes_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   mes_datapath #(
      .TRACKS        (TRACKS),
      .FIFO_DEPTH    (FIFO_DEPTH),
      .DELAY_DIVIDER (DELAY_DIVIDER)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .track_enable      (track_enable_ff),
      .req_track         (req_track),
      .req_event_delay   (req_event_delay),
      .req_event_message (req_event_message),
      .req_tick_delta    (req_tick_delta),
      .rsp_strobe        (rsp_strobe),
      .rsp_is_event      (rsp_is_event),
      .rsp_track_index   (rsp_track_index),
      .rsp_message       (rsp_message),
      .rsp_next_wait     (rsp_next_wait),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
